// File: rtl/core/tdwf_pkg.sv
// Types, constants and orientation helpers for the tile dedup block.
package tdwf_pkg;

    localparam int MAX_TILES_DEF = 256;
    localparam int ROWS          = 8;
    localparam int ROWS_W        = ROWS * 8;
    localparam int ATTR_W        = 8;

    localparam logic [1:0] ORIENT_SAME   = 2'd0;
    localparam logic [1:0] ORIENT_MIRROR = 2'd1;
    localparam logic [1:0] ORIENT_FLIP   = 2'd2;
    localparam logic [1:0] ORIENT_BOTH   = 2'd3;

    typedef struct packed {
        logic [ROWS_W-1:0] tile_rows;
        logic [ATTR_W-1:0] tile_attribute;
        logic              last_of_image;
    } tile_t;

    typedef struct packed {
        logic        is_new;
        logic [7:0]  tile_slot;
        logic [1:0]  orientation;
        logic [15:0] source_position;
        logic [8:0]  stored_count;
        logic        overflow;
    } result_t;

    // reverse the bits of every row
    function automatic logic [ROWS_W-1:0] mirror_rows(input logic [ROWS_W-1:0] t);
        logic [ROWS_W-1:0] r;
        r = '0;
        for (int row = 0; row < ROWS; row++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                r[row*8 + k] = t[row*8 + 7 - k];
            end
        end
        return r;
    endfunction

    // reverse the row order
    function automatic logic [ROWS_W-1:0] flip_rows(input logic [ROWS_W-1:0] t);
        logic [ROWS_W-1:0] r;
        r = '0;
        for (int row = 0; row < ROWS; row++)
        begin
            r[row*8 +: 8] = t[(ROWS-1-row)*8 +: 8];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/tile_dedup_with_flips.sv
// Top level: tile store with sequential search over stored tiles and flip matching.
//
//  channel   dir  handshake                 beat
//  tile      in   tile_valid/tile_ready     tdwf_pkg::tile_t
//  result    out  result_valid/result_ready tdwf_pkg::result_t
//  cfg       in   cfg_valid/cfg_ready       allow_flips
//
// A tile is compared against the stored tiles in turn, and the search ends early on a match;
// the single read port of the tile memory delivers one stored tile per cycle to the compare
// unit. tile_ready is low from accept until the result is loaded into the output register
// and comes back high with that load.
// A result waiting on result_ready holds the block in its final step.
// Reset clears the tile count and ordinal; no memory clearing pass.
module tile_dedup_with_flips #(
    parameter int MAX_TILES = tdwf_pkg::MAX_TILES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tile_valid,
    output logic              tile_ready,
    input  tdwf_pkg::tile_t   tile,
    output logic              result_valid,
    input  logic              result_ready,
    output tdwf_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              allow_flips
);

    localparam int SLOT_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CNT_W  = $clog2(MAX_TILES + 1);
    localparam int MEM_W  = tdwf_pkg::ROWS_W + tdwf_pkg::ATTR_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TILES);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    tdwf_pkg::tile_t         item_reg, item_next;
    logic [CNT_W-1:0]        iss_reg, iss_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic [SLOT_W-1:0]       rd_slot_reg, rd_slot_next;
    logic                    found_reg, found_next;
    logic [SLOT_W-1:0]       match_slot_reg, match_slot_next;
    logic [1:0]              match_code_reg, match_code_next;
    logic [CNT_W-1:0]        held_reg, held_next;
    logic [15:0]             ordinal_reg, ordinal_next;
    logic                    allow_reg, allow_next;
    logic                    out_valid_reg, out_valid_next;
    tdwf_pkg::result_t       out_reg, out_next;

    logic [MEM_W-1:0]        mem [MAX_TILES];
    logic [MEM_W-1:0]        rd_data_reg;
    logic                    rd_en;
    logic                    wr_en;

    logic [tdwf_pkg::ROWS_W-1:0] st_rows;
    logic [tdwf_pkg::ATTR_W-1:0] st_attr;
    logic                        attr_eq;
    logic [3:0]                  eq;
    logic                        hit;
    logic [1:0]                  hit_code;
    logic                        out_free;
    logic                        is_new;
    logic                        ovf;
    logic [CNT_W-1:0]            held_after;
    logic [SLOT_W-1:0]           res_slot;

    assign tile_ready   = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // shared compare unit: one stored tile per cycle, four orientations
    assign st_rows = rd_data_reg[MEM_W-1 -: tdwf_pkg::ROWS_W];
    assign st_attr = rd_data_reg[tdwf_pkg::ATTR_W-1:0];
    assign attr_eq = (st_attr == item_reg.tile_attribute);
    assign eq[0]   = (st_rows == item_reg.tile_rows);
    assign eq[1]   = allow_reg && (tdwf_pkg::mirror_rows(st_rows) == item_reg.tile_rows);
    assign eq[2]   = allow_reg && (tdwf_pkg::flip_rows(st_rows) == item_reg.tile_rows);
    assign eq[3]   = allow_reg && (tdwf_pkg::flip_rows(tdwf_pkg::mirror_rows(st_rows))
                                   == item_reg.tile_rows);
    assign hit     = rd_valid_reg && attr_eq && (eq != 4'b0000);

    always_comb
    begin
        if (eq[0])
            hit_code = tdwf_pkg::ORIENT_SAME;
        else if (eq[1])
            hit_code = tdwf_pkg::ORIENT_MIRROR;
        else if (eq[2])
            hit_code = tdwf_pkg::ORIENT_FLIP;
        else
            hit_code = tdwf_pkg::ORIENT_BOTH;
    end

    assign out_free   = !out_valid_reg || result_ready;
    assign is_new     = !found_reg && (held_reg < MAX_CNT);
    assign ovf        = !found_reg && (held_reg == MAX_CNT);
    assign held_after = held_reg + CNT_W'(is_new);
    assign res_slot   = found_reg ? match_slot_reg :
                        (is_new ? held_reg[SLOT_W-1:0] : '0);
    assign rd_en      = (state_reg == ST_SEARCH) && (iss_reg < held_reg);
    assign wr_en      = (state_reg == ST_FINISH) && out_free && is_new;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        iss_next        = iss_reg;
        rd_valid_next   = 1'b0;
        rd_slot_next    = rd_slot_reg;
        found_next      = found_reg;
        match_slot_next = match_slot_reg;
        match_code_next = match_code_reg;
        held_next       = held_reg;
        ordinal_next    = ordinal_reg;
        allow_next      = allow_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (cfg_valid)
            allow_next = allow_flips;
        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (tile_valid)
                begin
                    item_next  = tile;
                    iss_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    found_next      = 1'b1;
                    match_slot_next = rd_slot_reg;
                    match_code_next = hit_code;
                    state_next      = ST_FINISH;
                end
                else if (rd_en)
                begin
                    rd_valid_next = 1'b1;
                    rd_slot_next  = iss_reg[SLOT_W-1:0];
                    iss_next      = iss_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.is_new         = is_new;
                    out_next.tile_slot      = 8'(res_slot);
                    out_next.orientation    = found_reg ? match_code_reg
                                                        : tdwf_pkg::ORIENT_SAME;
                    out_next.source_position = ordinal_reg;
                    out_next.stored_count   = 9'(held_after);
                    out_next.overflow       = ovf;
                    if (item_reg.last_of_image)
                    begin
                        held_next    = '0;
                        ordinal_next = '0;
                    end
                    else
                    begin
                        held_next    = held_after;
                        ordinal_next = ordinal_reg + 16'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            held_reg      <= '0;
            ordinal_reg   <= '0;
            allow_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            held_reg      <= held_next;
            ordinal_reg   <= ordinal_next;
            allow_reg     <= allow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        iss_reg        <= iss_next;
        rd_slot_reg    <= rd_slot_next;
        found_reg      <= found_next;
        match_slot_reg <= match_slot_next;
        match_code_reg <= match_code_next;
        out_reg        <= out_next;
    end

    // tile memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[held_reg[SLOT_W-1:0]] <= {item_reg.tile_rows, item_reg.tile_attribute};
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[iss_reg[SLOT_W-1:0]];
    end

endmodule

// File: rtl/core/tdwf_checker.sv
// Port-level checks for the tile dedup block, bound to the top level.
module tdwf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              tile_valid,
    input logic              tile_ready,
    input logic              result_valid,
    input logic              result_ready,
    input tdwf_pkg::result_t result
);

    // tile_ready drops after an accept while the tile is searched
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        tile_valid && tile_ready |=> !tile_ready)
        else $error("tile_ready high right after accept");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_new_plain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_new |->
            !result.overflow && result.orientation == tdwf_pkg::ORIENT_SAME)
        else $error("new tile with overflow or orientation");

    a_overflow_slot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow |->
            result.tile_slot == 8'd0 && result.orientation == tdwf_pkg::ORIENT_SAME)
        else $error("overflow result with slot or orientation");

endmodule

bind tile_dedup_with_flips tdwf_checker u_tdwf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tile_valid   (tile_valid),
    .tile_ready   (tile_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
